/* rtl/lru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// Shared widths, register indexes and reset values for the lru page
// replacement unit.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int ADDR_W     = 31;
  localparam int PAGE_W     = 31;
  localparam int FRAME_W    = 4;
  localparam int CNT_W      = 32;
  localparam int NFRAMES_W  = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int DIV_STEPS  = 31;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE     = 8'd1;

  localparam logic [NFRAMES_W-1:0] FRAMES_IN_USE_RST = 5'd16;
  localparam logic [PAGE_W-1:0]    PAGE_SIZE_RST     = 31'd4096;

endpackage

/* rtl/lru_page_replacement_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative lru page table: page number by serial divide, tag scan,
// then hit promotion, empty fill or lru eviction.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It passes through
// the one-bit-per-cycle restoring divider, a scan of the page table through
// its single read port over n entries, n being the effective frames_in_use,
// and an update state. done is high for exactly one cycle with hit, frame,
// page_number, fault_count and reference_count valid; there is no way to
// stall it, so the receiver must take the item in that cycle. A new item
// may be started in the same cycle that done is high. Configuration is
// always ready and is meant to be written only while busy is low.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit #(
  parameter int FRAMES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [lru_pkg::ADDR_W-1:0]       address,
  output logic                             done,
  output logic                             hit,
  output logic [lru_pkg::FRAME_W-1:0]      frame,
  output logic [lru_pkg::PAGE_W-1:0]       page_number,
  output logic [lru_pkg::CNT_W-1:0]        fault_count,
  output logic [lru_pkg::CNT_W-1:0]        reference_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lru_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IdxW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW    = $clog2(FRAMES + 1);
  localparam int PageW   = lru_pkg::PAGE_W;
  localparam int FrameW  = lru_pkg::FRAME_W;
  localparam int NfW     = lru_pkg::NFRAMES_W;
  localparam int DivCntW = lru_pkg::DIV_CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t state;

  logic [NfW-1:0]   frames_in_use;
  logic [PageW-1:0] page_bytes;
  logic [PageW-1:0] divisor;
  logic [CntW-1:0]  n_eff;

  logic [PageW-1:0]   rem;
  logic [PageW-1:0]   page;
  logic [DivCntW-1:0] div_cnt;
  logic [PageW:0]     trial;
  logic [PageW:0]     trial_diff;
  logic               trial_ge;

  logic [FRAMES-1:0] valid;
  logic [FRAMES-1:0] valid_next;
  logic [IdxW-1:0]   age      [FRAMES];
  logic [IdxW-1:0]   age_next [FRAMES];

  logic [CntW-1:0]  scan_cnt;
  logic             cmp_pend;
  logic [IdxW-1:0]  cmp_idx;
  logic             cmp_valid;
  logic [IdxW-1:0]  cmp_age;
  logic [PageW-1:0] ram_rdata;

  logic            hit_found;
  logic [IdxW-1:0] hit_idx;
  logic            empty_found;
  logic [IdxW-1:0] empty_idx;
  logic [IdxW-1:0] victim_idx;
  logic [IdxW-1:0] victim_age;

  logic [IdxW-1:0] sel_frame;
  logic [IdxW-1:0] sel_age;
  logic            fill;
  logic            ram_we;

  assign busy        = (state != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign page_number = page;

  assign divisor = (page_bytes == '0) ? PageW'(1) : page_bytes;

  always_comb begin
    if (frames_in_use == '0) begin
      n_eff = CntW'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      n_eff = CntW'(FRAMES);
    end else begin
      n_eff = CntW'(frames_in_use);
    end
  end

  // restoring divider step
  assign trial      = {rem, page[PageW-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  assign cmp_valid = valid[cmp_idx];
  assign cmp_age   = age[cmp_idx];

  // replacement decision
  assign sel_frame = hit_found ? hit_idx : (empty_found ? empty_idx : victim_idx);
  assign sel_age   = age[sel_frame];
  assign fill      = !hit_found && empty_found;
  assign ram_we    = (state == S_UPDATE) && !hit_found;

  always_comb begin
    valid_next = valid;
    valid_next[sel_frame] = 1'b1;
    for (int i = 0; i < FRAMES; i++) begin
      age_next[i] = age[i];
      if (fill) begin
        if (valid[i]) begin
          age_next[i] = age[i] + 1'b1;
        end
      end else if ((IdxW'(i) != sel_frame) && valid[i] && (age[i] < sel_age)) begin
        age_next[i] = age[i] + 1'b1;
      end
    end
    age_next[sel_frame] = '0;
  end

  lru_ram #(
    .WIDTH (PageW),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel_frame),
    .wdata (page),
    .raddr (scan_cnt[IdxW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      valid           <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        age[i] <= '0;
      end
      fault_count     <= '0;
      reference_count <= '0;
      frames_in_use   <= lru_pkg::FRAMES_IN_USE_RST;
      page_bytes      <= lru_pkg::PAGE_SIZE_RST;
      cmp_pend        <= 1'b0;
      hit_found       <= 1'b0;
      empty_found     <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lru_pkg::CFG_FRAMES_IN_USE: frames_in_use <= cfg_data[NfW-1:0];
          lru_pkg::CFG_PAGE_SIZE:     page_bytes    <= cfg_data[PageW-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            rem     <= '0;
            page    <= address;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end

        S_DIV: begin
          rem  <= trial_ge ? trial_diff[PageW-1:0] : trial[PageW-1:0];
          page <= {page[PageW-2:0], trial_ge};
          if (div_cnt == DivCntW'(lru_pkg::DIV_STEPS - 1)) begin
            scan_cnt    <= '0;
            cmp_pend    <= 1'b0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            state       <= S_SCAN;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end

        S_SCAN: begin
          // read issued in the cycle before its compare
          if (scan_cnt < n_eff) begin
            cmp_pend <= 1'b1;
            cmp_idx  <= scan_cnt[IdxW-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            cmp_pend <= 1'b0;
            state    <= S_UPDATE;
          end
          if (cmp_pend) begin
            if (cmp_valid && (ram_rdata == page) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
            end
            if (!cmp_valid && !empty_found) begin
              empty_found <= 1'b1;
              empty_idx   <= cmp_idx;
            end
            if ((cmp_idx == '0) || (cmp_age > victim_age)) begin
              victim_idx <= cmp_idx;
              victim_age <= cmp_age;
            end
          end
        end

        S_UPDATE: begin
          valid <= valid_next;
          for (int i = 0; i < FRAMES; i++) begin
            age[i] <= age_next[i];
          end
          if (!hit_found && (fault_count != '1)) begin
            fault_count <= fault_count + 1'b1;
          end
          if (reference_count != '1) begin
            reference_count <= reference_count + 1'b1;
          end
          hit   <= hit_found;
          frame <= FrameW'(sel_frame);
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/lru_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module lru_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
